[rtl/assert_macros.svh]
// Assertion helpers shared by the draw engine modules.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/crbde_pkg.sv]
// ----------------------------------------------------------------------------
// crbde_pkg
// Shared widths, codes and controller/datapath interface types for the
// clipped rectangle blend draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crbde_pkg;

    localparam int COORD_W   = 11;
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int WEIGHT_W  = 8;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 1;
    localparam int SEG_W     = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [COORD_W-1:0] FRAME_W_RESET = 11'd800;
    localparam logic [COORD_W-1:0] FRAME_H_RESET = 11'd600;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // command opcodes
    localparam logic [OP_W-1:0] OP_FILL    = 3'd0;
    localparam logic [OP_W-1:0] OP_HLINE   = 3'd1;
    localparam logic [OP_W-1:0] OP_VLINE   = 3'd2;
    localparam logic [OP_W-1:0] OP_OUTLINE = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    // outline edges, walked in this order
    localparam logic [SEG_W-1:0] SEG_TOP    = 2'd0;
    localparam logic [SEG_W-1:0] SEG_BOTTOM = 2'd1;
    localparam logic [SEG_W-1:0] SEG_LEFT   = 2'd2;
    localparam logic [SEG_W-1:0] SEG_RIGHT  = 2'd3;
    localparam logic [SEG_W-1:0] SEG_LAST   = SEG_RIGHT;

    typedef struct packed {
        logic             load;   // latch a new request
        logic             setup;  // clip segment and load walker
        logic             step;   // issue one pixel
        logic [SEG_W-1:0] seg;    // segment being set up
    } dp_cmd_t;

    typedef struct packed {
        logic seg_empty;  // clipped segment holds no pixel
        logic seg_last;   // walker sits on the segment's last pixel
        logic pipe_busy;  // read/blend pipeline still holds pixels
        logic multi_seg;  // request is an outline
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/crbde_ctrl.sv]
// ----------------------------------------------------------------------------
// crbde_ctrl
// Request sequencer: accepts a request, steps through its clipped segments,
// waits for the pixel pipeline to empty and pulses done.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module crbde_ctrl
    import crbde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    output logic            done,
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic             done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.seg    = seg_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    seg_next   = SEG_TOP;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                cmd.step = !status.seg_empty;
                if (status.seg_empty || status.seg_last)
                begin
                    if (status.multi_seg && (seg_reg != SEG_LAST))
                    begin
                        seg_next   = seg_reg + SEG_W'(1);
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seg_reg   <= SEG_TOP;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted request did not raise busy")
    `ASSERT_NEXT(a_done_single, done_reg, !done_reg, "done held longer than one cycle")
    `ASSERT_IMPL(a_step_in_walk, cmd.step, state_reg == S_WALK && !status.seg_empty,
                 "pixel issued outside a non-empty segment walk")

endmodule

`default_nettype wire

[rtl/crbde_datapath.sv]
// ----------------------------------------------------------------------------
// crbde_datapath
// Frame registers, request latch, segment clipper, pixel walker, frame
// memory and the read / blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module crbde_datapath
    import crbde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [COORD_W-1:0]   pos_x,
    input  wire logic [COORD_W-1:0]   pos_y,
    input  wire logic [COORD_W-1:0]   extent_w,
    input  wire logic [COORD_W-1:0]   extent_h,
    input  wire logic [COLOR_W-1:0]   rgb_color,
    input  wire logic [WEIGHT_W-1:0]  blend_weight,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic [COLOR_W-1:0]        pixel_value,
    output logic                      inside_frame
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LIM_W   = COORD_W + 2;
    localparam int PROD_W  = 2 * COORD_W + 1;
    localparam int NCHAN   = COLOR_W / CHAN_W;
    localparam int MULT_W  = 2 * CHAN_W;

    localparam logic [COORD_W-1:0] ONE = COORD_W'(1);
    localparam logic [MULT_W-1:0]  CHAN_FULL = MULT_W'((1 << CHAN_W) - 1);

    // ---------------- frame size registers ----------------
    logic [COORD_W-1:0] frame_width_reg, frame_height_reg;
    logic [COORD_W-1:0] eff_w, eff_h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_W_RESET;
            frame_height_reg <= FRAME_H_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    assign eff_w = ({2'b00, frame_width_reg} > LIM_W'(MAX_WIDTH)) ?
                   COORD_W'(MAX_WIDTH) : frame_width_reg;
    assign eff_h = ({2'b00, frame_height_reg} > LIM_W'(MAX_HEIGHT)) ?
                   COORD_W'(MAX_HEIGHT) : frame_height_reg;

    // ---------------- request latch ----------------
    logic [OP_W-1:0]     op_reg;
    logic [COORD_W-1:0]  px_reg, py_reg, ew_reg, eh_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                is_fill, is_read;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op;
            px_reg     <= pos_x;
            py_reg     <= pos_y;
            ew_reg     <= extent_w;
            eh_reg     <= extent_h;
            color_reg  <= rgb_color;
            weight_reg <= blend_weight;
        end
    end

    assign is_fill = (op_reg == OP_FILL);
    assign is_read = (op_reg == OP_READ);

    // ---------------- segment select and clip ----------------
    // Every request is one or four rectangles clipped to the frame.
    logic [COORD_W:0]   sx, sy;
    logic [COORD_W-1:0] sw, sh;
    logic               op_ok;
    logic [COORD_W+1:0] x_sum, y_sum;
    logic [COORD_W-1:0] x_end, y_end;
    logic               seg_empty_next;
    logic [PROD_W-1:0]  base_prod;

    always_comb
    begin
        sx    = {1'b0, px_reg};
        sy    = {1'b0, py_reg};
        sw    = ew_reg;
        sh    = eh_reg;
        op_ok = 1'b1;
        unique case (op_reg)
            OP_FILL:  op_ok = 1'b1;
            OP_HLINE: sh = ONE;
            OP_VLINE: sw = ONE;
            OP_OUTLINE:
            begin
                unique case (cmd.seg)
                    SEG_TOP:    sh = ONE;
                    SEG_BOTTOM:
                    begin
                        sy = {1'b0, py_reg} + {1'b0, eh_reg};
                        sh = ONE;
                    end
                    SEG_LEFT:   sw = ONE;
                    SEG_RIGHT:
                    begin
                        sx = {1'b0, px_reg} + {1'b0, ew_reg};
                        sw = ONE;
                    end
                    default:    sw = ONE;
                endcase
            end
            OP_READ:
            begin
                sw = ONE;
                sh = ONE;
            end
            default:  op_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        x_sum = {1'b0, sx} + {2'b00, sw};
        y_sum = {1'b0, sy} + {2'b00, sh};
        x_end = (x_sum < {2'b00, eff_w}) ? x_sum[COORD_W-1:0] : eff_w;
        y_end = (y_sum < {2'b00, eff_h}) ? y_sum[COORD_W-1:0] : eff_h;
        seg_empty_next = !op_ok || (sx >= {1'b0, x_end}) || (sy >= {1'b0, y_end});
        base_prod = sy * eff_w;
    end

    // ---------------- pixel walker ----------------
    logic [COORD_W-1:0] xs_reg, x_end_reg, y_end_reg, cur_x_reg, cur_y_reg;
    logic [ADDR_W-1:0]  row_base_reg;
    logic               seg_empty_reg;
    logic               row_end, seg_last;
    logic [ADDR_W-1:0]  issue_addr;

    assign row_end  = (({1'b0, cur_x_reg} + (COORD_W+1)'(1)) == {1'b0, x_end_reg});
    assign seg_last = row_end &&
                      (({1'b0, cur_y_reg} + (COORD_W+1)'(1)) == {1'b0, y_end_reg});
    assign issue_addr = row_base_reg + ADDR_W'(cur_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_empty_reg <= 1'b1;
        end
        else if (cmd.setup)
        begin
            seg_empty_reg <= seg_empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            xs_reg       <= sx[COORD_W-1:0];
            cur_x_reg    <= sx[COORD_W-1:0];
            cur_y_reg    <= sy[COORD_W-1:0];
            x_end_reg    <= x_end;
            y_end_reg    <= y_end;
            row_base_reg <= ADDR_W'(base_prod);
        end
        else if (cmd.step)
        begin
            if (row_end)
            begin
                cur_x_reg    <= xs_reg;
                cur_y_reg    <= cur_y_reg + ONE;
                row_base_reg <= row_base_reg + ADDR_W'(eff_w);
            end
            else
            begin
                cur_x_reg <= cur_x_reg + ONE;
            end
        end
    end

    // ---------------- frame memory ----------------
    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    logic               mem_we, we_solid;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;

    // ---------------- read / blend pipeline ----------------
    // issue -> memory read -> products -> divide by 255 and write back
    logic               v1_reg, v2_reg;
    logic [ADDR_W-1:0]  addr1_reg, addr2_reg;
    logic [MULT_W-1:0]  prod_new_reg [NCHAN];
    logic [MULT_W-1:0]  prod_old_reg [NCHAN];
    logic [COLOR_W-1:0] blend_pix;

    function automatic logic [CHAN_W-1:0] div255(input logic [MULT_W-1:0] v);
        logic [MULT_W-1:0] t;
        // exact floor(v / 255) for v up to 255 * 255
        t = v + {{CHAN_W{1'b0}}, v[MULT_W-1:CHAN_W]} + MULT_W'(1);
        return t[MULT_W-1:CHAN_W];
    endfunction

    always_comb
    begin
        for (int c = 0; c < NCHAN; c++)
        begin
            blend_pix[c*CHAN_W +: CHAN_W] = div255(prod_new_reg[c] + prod_old_reg[c]);
        end
    end

    assign we_solid  = cmd.step && !is_fill && !is_read;
    assign mem_we    = we_solid || v2_reg;
    assign mem_waddr = v2_reg ? addr2_reg : issue_addr;
    assign mem_wdata = v2_reg ? blend_pix : color_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[issue_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.step && (is_fill || is_read);
            v2_reg <= v1_reg && is_fill;
        end
    end

    always_ff @(posedge clk)
    begin
        addr1_reg <= issue_addr;
        addr2_reg <= addr1_reg;
        for (int c = 0; c < NCHAN; c++)
        begin
            prod_new_reg[c] <= (CHAN_FULL - MULT_W'(weight_reg)) *
                               MULT_W'(color_reg[c*CHAN_W +: CHAN_W]);
            prod_old_reg[c] <= MULT_W'(weight_reg) *
                               MULT_W'(rd_data_reg[c*CHAN_W +: CHAN_W]);
        end
    end

    // ---------------- result registers ----------------
    logic [COLOR_W-1:0] pix_reg;
    logic               inside_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg    <= '0;
            inside_reg <= (pos_x < eff_w) && (pos_y < eff_h);
        end
        else if (v1_reg && is_read)
        begin
            pix_reg <= rd_data_reg;
        end
    end

    assign pixel_value  = pix_reg;
    assign inside_frame = inside_reg;

    assign status.seg_empty = seg_empty_reg;
    assign status.seg_last  = seg_last;
    assign status.pipe_busy = v1_reg || v2_reg;
    assign status.multi_seg = (op_reg == OP_OUTLINE);

    `ASSERT_NEXT(a_fill_pipe, v1_reg && is_fill && !cmd.load, v2_reg,
                 "blend read did not reach write-back stage")
    `ASSERT_IMPL(a_single_writer, v2_reg, !we_solid, "solid write collides with blend write")
    `ASSERT_IMPL(a_read_no_write, v1_reg && is_read, !mem_we, "frame written during a pixel read")

endmodule

`default_nettype wire

[rtl/clipped_rect_blend_draw_engine.sv]
// ----------------------------------------------------------------------------
// clipped_rect_blend_draw_engine
// 2D draw engine over a 24-bit RGB frame memory: blended fill, lines,
// outline and pixel read, all clipped to the programmed frame size.
//
//   channel   handshake                 payload
//   request   start / busy              op, pos_x, pos_y, extent_w, extent_h,
//                                       rgb_color, blend_weight
//   result    done (1-cycle strobe)     pixel_value, inside_frame
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A request is accepted, then each segment passes a setup state and a walk
// that issues one clipped pixel per cycle (a segment that clips to nothing
// issues none), then a drain state waits until the read / blend pipeline is
// empty; an outline has four segments, every other request one.
// done pulses in the first cycle with busy low, and a new request may start in
// that cycle. The result side cannot stall; start simply waits while busy.
// Reset restores the 800 x 600 frame size and clears control state; the frame
// memory holds no defined value until written. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rect_blend_draw_engine
    import crbde_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [COORD_W-1:0]   pos_x,
    input  wire logic [COORD_W-1:0]   pos_y,
    input  wire logic [COORD_W-1:0]   extent_w,
    input  wire logic [COORD_W-1:0]   extent_h,
    input  wire logic [COLOR_W-1:0]   rgb_color,
    input  wire logic [WEIGHT_W-1:0]  blend_weight,
    output logic                      done,
    output logic [COLOR_W-1:0]        pixel_value,
    output logic                      inside_frame,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    crbde_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd),
        .status (status)
    );

    crbde_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .extent_w     (extent_w),
        .extent_h     (extent_h),
        .rgb_color    (rgb_color),
        .blend_weight (blend_weight),
        .cmd          (cmd),
        .status       (status),
        .pixel_value  (pixel_value),
        .inside_frame (inside_frame)
    );

endmodule

`default_nettype wire
